/* rtl/core/nbm_pkg.sv */
package nbm_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_PRG   = 2'd2;
  localparam logic [1:0] ACT_CHR   = 2'd3;

  localparam logic [15:0] ADDR_PRG   = 16'h8000;
  localparam logic [15:0] ADDR_CHR1K = 16'hA000;
  localparam logic [15:0] ADDR_IRQ   = 16'hC000;
  localparam logic [15:0] ADDR_MIRR  = 16'hE000;
  localparam logic [15:0] ADDR_CHR_END = 16'h2000;

  localparam logic [7:0] CNT_WRAP = 8'hFF;
  localparam int unsigned MIRR_BIT = 6;

  localparam int unsigned BankEntries = 8;
  localparam int unsigned BankIdxW    = 3;

  localparam logic [BankIdxW-1:0] IDX_PRG_A = 3'd0;
  localparam logic [BankIdxW-1:0] IDX_PRG_B = 3'd1;
  localparam logic [BankIdxW-1:0] IDX_CHR2K = 3'd2;
  localparam logic [BankIdxW-1:0] IDX_CHR1K = 3'd4;

  localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
  localparam logic [1:0] CFG_MIRROR    = 2'd2;

  typedef struct packed {
    logic mirror_wr;
    logic lock_wr;
    logic cnt_load;
    logic tick;
  } cmd_t;

  function automatic logic [7:0] bank_init(input logic [BankIdxW-1:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'd0;
      3'd1: v = 8'd1;
      3'd2: v = 8'd0;
      3'd3: v = 8'd1;
      3'd4: v = 8'd4;
      3'd5: v = 8'd5;
      3'd6: v = 8'd6;
      3'd7: v = 8'd7;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/nbm_bank_ram.sv */
module nbm_bank_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [nbm_pkg::BankIdxW-1:0]  waddr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          re_i,
  input  logic [nbm_pkg::BankIdxW-1:0]  raddr_i,
  output logic [7:0]                    rdata_o
);

  logic [7:0] mem [nbm_pkg::BankEntries];
  logic [nbm_pkg::BankEntries-1:0] valid_q;
  logic [7:0] rd_q;
  logic       rd_valid_q;
  logic [nbm_pkg::BankIdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
      rd_idx_q <= raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  // untouched entries read as their reset bank
  assign rdata_o = rd_valid_q ? rd_q : nbm_pkg::bank_init(rd_idx_q);

endmodule

/* rtl/core/nbm_state.sv */
module nbm_state #(
  parameter logic [8:0] VisLines = 9'd240
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nbm_pkg::cmd_t cmd_i,
  input  logic [7:0]    data_i,
  input  logic          cnt_en_val_i,
  input  logic [8:0]    scanline_i,
  input  logic          display_on_i,
  input  logic          cfg_mirror_we_i,
  input  logic          cfg_mirror_i,
  output logic          mirror_d_o,
  output logic          irq_d_o
);

  logic       mirror_q, mirror_d;
  logic       locked_q, locked_d;
  logic       cnt_en_q, cnt_en_d;
  logic [7:0] cnt_q, cnt_d;
  logic       irq_q, irq_d;
  logic       mbit;

  assign mbit = data_i[nbm_pkg::MIRR_BIT];

  always_comb begin
    mirror_d = mirror_q;
    locked_d = locked_q;
    cnt_en_d = cnt_en_q;
    cnt_d    = cnt_q;
    irq_d    = irq_q;
    if (cmd_i.mirror_wr && !locked_q) begin
      mirror_d = mbit;
    end
    if (cmd_i.lock_wr) begin
      mirror_d = mbit;
      locked_d = 1'b1;
    end
    if (cfg_mirror_we_i && !locked_q) begin
      mirror_d = cfg_mirror_i;
    end
    if (cmd_i.cnt_load) begin
      cnt_d    = data_i;
      cnt_en_d = cnt_en_val_i;
      irq_d    = 1'b0;
    end
    if (cmd_i.tick && (scanline_i < VisLines) && display_on_i && cnt_en_q) begin
      if (cnt_q == nbm_pkg::CNT_WRAP) begin
        irq_d = 1'b1;
      end
      cnt_d = cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= 1'b0;
      locked_q <= 1'b0;
      cnt_en_q <= 1'b0;
      cnt_q    <= 8'd0;
      irq_q    <= 1'b0;
    end else begin
      mirror_q <= mirror_d;
      locked_q <= locked_d;
      cnt_en_q <= cnt_en_d;
      cnt_q    <= cnt_d;
      irq_q    <= irq_d;
    end
  end

  assign mirror_d_o = mirror_d;
  assign irq_d_o    = irq_d;

endmodule

/* rtl/core/nbm_xlate.sv */
module nbm_xlate (
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  bank_i,
  input  logic [8:0]  prg_count_i,
  input  logic [9:0]  chr_count_i,
  output logic [8:0]  mapped_bank_o
);

  logic [8:0] prg_mask;
  logic [8:0] prg_bank;
  logic [9:0] chr_mask_w;
  logic [8:0] chr_bank;
  logic [2:0] slot;

  assign slot       = address_i[12:10];
  assign prg_mask   = prg_count_i - 9'd1;
  assign chr_mask_w = chr_count_i - 10'd1;

  always_comb begin
    case (address_i[14:13])
      2'd0, 2'd1: prg_bank = {1'b0, bank_i};
      2'd2:       prg_bank = prg_count_i - 9'd2;
      default:    prg_bank = prg_count_i - 9'd1;
    endcase
    if (!slot[2]) begin
      chr_bank = {bank_i, slot[0]};
    end else begin
      chr_bank = {1'b0, bank_i};
    end
  end

  always_comb begin
    mapped_bank_o = 9'd0;
    case (action_i)
      nbm_pkg::ACT_PRG: begin
        if (address_i >= nbm_pkg::ADDR_PRG) begin
          mapped_bank_o = prg_bank & prg_mask;
        end
      end
      nbm_pkg::ACT_CHR: begin
        if (address_i < nbm_pkg::ADDR_CHR_END) begin
          if (chr_count_i == 10'd0) begin
            mapped_bank_o = {6'd0, slot};
          end else begin
            mapped_bank_o = chr_bank & chr_mask_w[8:0];
          end
        end
      end
      default: mapped_bank_o = 9'd0;
    endcase
  end

endmodule

/* rtl/core/nes_bank_mapper_irq_core.sv */
// Bank mapper with scanline interrupt counter. Takes one item per cycle when the
// result side keeps up; each item gives one result, first reading the eight-entry
// bank register memory (one read port, registered read data) and then, once the
// output stage is free to take it, translating the address into the output
// register. Register writes update the bank memory and the control state at the
// transfer edge, so the next item already sees them. Configuration writes are
// taken at any time but belong only to an idle block; no clearing pass is needed
// after reset.
module nes_bank_mapper_irq_core #(
  parameter int unsigned VISIBLE_LINES = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [8:0]  scanline_i,
  input  logic        display_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  mapped_bank_o,
  output logic        mirror_mode_o,
  output logic        irq_out_o,
  output logic        reg_hit_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  localparam logic [8:0] VisLines = 9'(VISIBLE_LINES);

  logic accept, s1_adv;
  logic is_wr;
  logic wr_bank, wr_irq, wr_dummy, wr_mirr;
  logic hit;
  logic [nbm_pkg::BankIdxW-1:0] waddr, raddr;
  logic [7:0] rdata;
  nbm_pkg::cmd_t cmd;
  logic mirror_next, irq_next;
  logic [8:0] xl_bank;

  logic [8:0] prg_cnt_q;
  logic [9:0] chr_cnt_q;

  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_act_q;
  logic [15:0] s1_addr_q;
  logic        s1_mirror_q, s1_irq_q, s1_hit_q;

  logic        out_valid_q, out_valid_d;
  logic [8:0]  out_bank_q;
  logic        out_mirror_q, out_irq_q, out_hit_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // register decode
  assign is_wr    = accept && (action_i == nbm_pkg::ACT_WRITE);
  assign wr_bank  = (address_i[15:2] == nbm_pkg::ADDR_PRG[15:2]) ||
                    (address_i[15:2] == nbm_pkg::ADDR_CHR1K[15:2]);
  assign wr_irq   = (address_i[15:1] == nbm_pkg::ADDR_IRQ[15:1]);
  assign wr_dummy = (address_i[15:2] == nbm_pkg::ADDR_IRQ[15:2]);
  assign wr_mirr  = (address_i == nbm_pkg::ADDR_MIRR);
  assign hit      = wr_bank || wr_dummy || wr_mirr;

  assign waddr = address_i[13] ? (nbm_pkg::IDX_CHR1K | {1'b0, address_i[1:0]})
                               : {1'b0, address_i[1:0]};

  always_comb begin
    if (action_i == nbm_pkg::ACT_PRG) begin
      raddr = address_i[13] ? nbm_pkg::IDX_PRG_B : nbm_pkg::IDX_PRG_A;
    end else if (address_i[12]) begin
      raddr = nbm_pkg::IDX_CHR1K | {1'b0, address_i[11:10]};
    end else begin
      raddr = nbm_pkg::IDX_CHR2K | {2'b0, address_i[11]};
    end
  end

  assign cmd.mirror_wr = is_wr && (address_i == nbm_pkg::ADDR_PRG);
  assign cmd.lock_wr   = is_wr && wr_mirr;
  assign cmd.cnt_load  = is_wr && wr_irq;
  assign cmd.tick      = accept && (action_i == nbm_pkg::ACT_TICK);

  nbm_bank_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (is_wr && wr_bank),
    .waddr_i (waddr),
    .wdata_i (data_i),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nbm_state #(
    .VisLines (VisLines)
  ) u_state (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .data_i          (data_i),
    .cnt_en_val_i    (address_i[0]),
    .scanline_i      (scanline_i),
    .display_on_i    (display_on_i),
    .cfg_mirror_we_i (cfg_we_i && (cfg_index_i == nbm_pkg::CFG_MIRROR)),
    .cfg_mirror_i    (cfg_data_i[0]),
    .mirror_d_o      (mirror_next),
    .irq_d_o         (irq_next)
  );

  nbm_xlate u_xlate (
    .action_i      (s1_act_q),
    .address_i     (s1_addr_q),
    .bank_i        (rdata),
    .prg_count_i   (prg_cnt_q),
    .chr_count_i   (chr_cnt_q),
    .mapped_bank_o (xl_bank)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q <= 9'd16;
      chr_cnt_q <= 10'd128;
    end else if (cfg_we_i) begin
      if (cfg_index_i == nbm_pkg::CFG_PRG_COUNT) begin
        prg_cnt_q <= cfg_data_i[8:0];
      end
      if (cfg_index_i == nbm_pkg::CFG_CHR_COUNT) begin
        chr_cnt_q <= cfg_data_i;
      end
    end
  end

  assign s1_valid_d  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q    <= action_i;
      s1_addr_q   <= address_i;
      s1_mirror_q <= mirror_next;
      s1_irq_q    <= irq_next;
      s1_hit_q    <= is_wr && hit;
    end
    if (s1_adv) begin
      out_bank_q   <= xl_bank;
      out_mirror_q <= s1_mirror_q;
      out_irq_q    <= s1_irq_q;
      out_hit_q    <= s1_hit_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mapped_bank_o = out_bank_q;
  assign mirror_mode_o = out_mirror_q;
  assign irq_out_o     = out_irq_q;
  assign reg_hit_o     = out_hit_q;

  // a counter write always leaves the interrupt low
  a_irq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_load |=> (s1_valid_q && !s1_irq_q))
    else $error("interrupt not cleared by counter write");

  // register writes never carry a bank number
  a_hit_no_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && reg_hit_o) |-> (mapped_bank_o == 9'd0))
    else $error("bank on register write result");

  // a held result with a full stage blocks new transfers
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("pipeline overrun");

endmodule

/* tb/nes_bank_mapper_irq_core_tb.sv */
`timescale 1ns / 1ps

module nes_bank_mapper_irq_core_tb;
  import nbm_pkg::*;

  localparam int unsigned VISIBLE_LINES = 240;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        display_on;
  } bus_item_t;

  typedef struct packed {
    logic [8:0] bank;
    logic       mirror;
    logic       irq;
    logic       hit;
  } map_result_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_value;
    bus_item_t   item;
    bit          typed;
    map_result_t result;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [15:0] address_i = '0;
  logic [7:0]  data_i = '0;
  logic [8:0]  scanline_i = '0;
  logic        display_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [8:0]  mapped_bank_o;
  logic        mirror_mode_o;
  logic        irq_out_o;
  logic        reg_hit_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i = '0;

  nes_bank_mapper_irq_core #(
    .VISIBLE_LINES(VISIBLE_LINES)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .action_i(action_i),
    .address_i(address_i),
    .data_i(data_i),
    .scanline_i(scanline_i),
    .display_on_i(display_on_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .mapped_bank_o(mapped_bank_o),
    .mirror_mode_o(mirror_mode_o),
    .irq_out_o(irq_out_o),
    .reg_hit_o(reg_hit_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // mapper state as seen by the predictor, at reset values
  logic [8:0] prg_count = 9'd16;
  logic [9:0] chr_count = 10'd128;
  logic [7:0] prg_a = 8'd0;
  logic [7:0] prg_b = 8'd1;
  logic [7:0] chr_2k [2] = '{8'd0, 8'd1};
  logic [7:0] chr_1k [4] = '{8'd4, 8'd5, 8'd6, 8'd7};
  logic       mirror_bit = 1'b0;
  logic       mirror_locked = 1'b0;
  logic       count_en = 1'b0;
  logic [7:0] line_count = 8'd0;
  logic       irq_pend = 1'b0;

  map_result_t results_due [$];
  stim_row_t   directed_rows [$];
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned counter_wraps = 0;
  int unsigned quiet_cycles = 0;

  int unsigned phase_prg [8] = '{16, 2, 256, 0, 100, 8, 128, 4};
  int unsigned phase_chr [8] = '{128, 0, 512, 1, 300, 8, 64, 0};
  int unsigned phase_mirr [8] = '{1, 0, 1, 0, 1, 0, 1, 0};

  function automatic map_result_t map_predict(bus_item_t it);
    map_result_t r;
    logic [8:0]  bank9;
    logic [9:0]  chr_mask;
    logic [2:0]  slot;
    r = '0;
    case (it.action)
      ACT_WRITE: begin
        r.hit = 1'b1;
        case (it.address)
          ADDR_PRG: begin
            if (!mirror_locked) mirror_bit = it.data[MIRR_BIT];
            prg_a = it.data;
          end
          ADDR_PRG + 16'd1: prg_b = it.data;
          ADDR_PRG + 16'd2: chr_2k[0] = it.data;
          ADDR_PRG + 16'd3: chr_2k[1] = it.data;
          ADDR_CHR1K, ADDR_CHR1K + 16'd1, ADDR_CHR1K + 16'd2, ADDR_CHR1K + 16'd3:
            chr_1k[it.address[1:0]] = it.data;
          ADDR_IRQ, ADDR_IRQ + 16'd1: begin
            line_count = it.data;
            count_en = it.address[0];
            irq_pend = 1'b0;
          end
          ADDR_IRQ + 16'd2, ADDR_IRQ + 16'd3: ;
          ADDR_MIRR: begin
            mirror_bit = it.data[MIRR_BIT];
            mirror_locked = 1'b1;
          end
          default: r.hit = 1'b0;
        endcase
      end
      ACT_TICK: begin
        if (it.scanline < VISIBLE_LINES && it.display_on && count_en) begin
          if (line_count == CNT_WRAP) begin
            irq_pend = 1'b1;
            counter_wraps++;
          end
          line_count = line_count + 8'd1;
        end
      end
      ACT_PRG: begin
        if (it.address >= ADDR_PRG) begin
          case (it.address[14:13])
            2'd0: bank9 = {1'b0, prg_a};
            2'd1: bank9 = {1'b0, prg_b};
            2'd2: bank9 = prg_count - 9'd2;
            default: bank9 = prg_count - 9'd1;
          endcase
          r.bank = bank9 & (prg_count - 9'd1);
        end
      end
      default: begin
        if (it.address < ADDR_CHR_END) begin
          slot = it.address[12:10];
          if (chr_count == 10'd0) begin
            r.bank = {6'd0, slot};
          end else begin
            if (!slot[2]) bank9 = {chr_2k[slot[1]], slot[0]};
            else bank9 = {1'b0, chr_1k[slot[1:0]]};
            chr_mask = chr_count - 10'd1;
            r.bank = bank9 & chr_mask[8:0];
          end
        end
      end
    endcase
    r.mirror = mirror_bit;
    r.irq = irq_pend;
    return r;
  endfunction

  function automatic bus_item_t bus(logic [1:0] act, logic [15:0] addr, logic [7:0] data = '0,
                                    logic [8:0] line = '0, logic shown = 1'b0);
    bus_item_t it;
    it.action = act;
    it.address = addr;
    it.data = data;
    it.scanline = line;
    it.display_on = shown;
    return it;
  endfunction

  function automatic void add_row(bus_item_t it, bit typed = 1'b0, logic [8:0] bank = '0,
                                  logic mirr = 1'b0, logic irq = 1'b0, logic hit = 1'b0);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_index = '0;
    row.cfg_value = '0;
    row.item = it;
    row.typed = typed;
    row.result = '{bank: bank, mirror: mirr, irq: irq, hit: hit};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [9:0] value);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.cfg_index = idx;
    row.cfg_value = value;
    row.item = '0;
    row.typed = 1'b0;
    row.result = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic bit roll_idle(bit send_side);
    case (idle_mode)
      IDLE_SEND: return send_side && $urandom_range(99) < 56;
      IDLE_RECV: return !send_side && $urandom_range(99) < 56;
      IDLE_BOTH: return $urandom_range(99) < 14;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bus_item_t random_item();
    bus_item_t   it;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    it.action = ACT_PRG;
    it.address = 16'($urandom);
    it.data = 8'($urandom);
    it.scanline = 9'($urandom_range(261));
    it.display_on = $urandom_range(99) < 85;
    if (pick < 35) begin
      it.action = ACT_WRITE;
      sel = $urandom_range(99);
      if (sel < 2) begin
        it.address = ADDR_MIRR;
      end else if (sel >= 22) begin
        case ($urandom_range(2))
          0: it.address = ADDR_PRG;
          1: it.address = ADDR_CHR1K;
          default: it.address = ADDR_IRQ;
        endcase
        it.address[1:0] = 2'($urandom_range(3));
        // counter loads close to wrap so that ticks reach the interrupt
        if (it.address == ADDR_IRQ + 16'd1 && $urandom_range(1))
          it.data = 8'($urandom_range(255, 250));
      end
    end else if (pick < 65) begin
      it.action = ACT_TICK;
      if ($urandom_range(99) < 80) it.scanline = 9'($urandom_range(VISIBLE_LINES - 1));
    end else if (pick >= 85) begin
      it.action = ACT_CHR;
      if ($urandom_range(3) != 0) it.address[15:13] = 3'd0;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_item(bus_item_t it, bit typed, map_result_t typed_res);
    map_result_t pred;
    bit          taken;
    @(negedge clk_i);
    while (roll_idle(1'b1)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= it.action;
    address_i <= it.address;
    data_i <= it.data;
    scanline_i <= it.scanline;
    display_on_i <= it.display_on;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_ready_o;
      if (!taken) @(negedge clk_i);
    end
    pred = map_predict(it);
    results_due.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic idle_bus();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [9:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PRG_COUNT: prg_count = value[8:0];
      CFG_CHR_COUNT: chr_count = value;
      CFG_MIRROR: begin
        if (!mirror_locked) mirror_bit = value[0];
      end
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !roll_idle(1'b0);
  end

  always @(posedge clk_i) begin : check_results
    map_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch("result with no transfer pending, bank", mapped_bank_o, 0);
      end else begin
        want = results_due.pop_front();
        if (mapped_bank_o !== want.bank) report_mismatch("mapped_bank", mapped_bank_o, want.bank);
        if (mirror_mode_o !== want.mirror)
          report_mismatch("mirror_mode", mirror_mode_o, want.mirror);
        if (irq_out_o !== want.irq) report_mismatch("irq_out", irq_out_o, want.irq);
        if (reg_hit_o !== want.hit) report_mismatch("reg_hit", reg_hit_o, want.hit);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("nes_bank_mapper_irq_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset banks: program 16 banks, pattern 128 banks, mirroring 0; then bank register writes and reads
    add_row(bus(ACT_PRG, ADDR_PRG), 1'b1, 9'd0, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_PRG, 16'hBFFF), 1'b1, 9'd1, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_PRG, ADDR_IRQ), 1'b1, 9'd14, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_PRG, 16'hFFFF), 1'b1, 9'd15, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_PRG, 16'h7FFF), 1'b1, 9'd0, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_CHR, 16'h0000), 1'b1, 9'd0, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_CHR, 16'h1FFF), 1'b1, 9'd7, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_CHR, 16'hFFFF), 1'b1, 9'd0, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_WRITE, ADDR_PRG, 8'hC5), 1'b1, 9'd0, 1'b1, 1'b0, 1'b1);
    add_row(bus(ACT_WRITE, 16'h0000, 8'hFF), 1'b1, 9'd0, 1'b1, 1'b0, 1'b0);
    add_row(bus(ACT_WRITE, ADDR_IRQ + 16'd3, 8'hFF), 1'b1, 9'd0, 1'b1, 1'b0, 1'b1);
    add_row(bus(ACT_WRITE, ADDR_PRG + 16'd1, 8'hFF));
    add_row(bus(ACT_WRITE, ADDR_PRG + 16'd2, 8'h7F));
    add_row(bus(ACT_WRITE, ADDR_CHR1K + 16'd3, 8'hA5));
    add_row(bus(ACT_PRG, ADDR_PRG + 16'h1FFF));
    add_row(bus(ACT_CHR, 16'h0C00));
    add_row(bus(ACT_CHR, 16'h1C00));
    // pattern ram, then a program size of zero
    add_cfg(CFG_CHR_COUNT, 10'd0);
    add_row(bus(ACT_CHR, 16'h1C00), 1'b1, 9'd7, 1'b1, 1'b0, 1'b0);
    add_cfg(CFG_PRG_COUNT, 10'd0);
    add_row(bus(ACT_PRG, 16'hFFFF), 1'b1, 9'd511, 1'b1, 1'b0, 1'b0);
    // counter wrap and interrupt clear
    add_row(bus(ACT_WRITE, ADDR_IRQ + 16'd1, 8'hFE));
    add_row(bus(ACT_TICK, 16'h0000, 8'h00, 9'd0, 1'b1));
    add_row(bus(ACT_TICK, 16'h0000, 8'h00, 9'd240, 1'b1));
    add_row(bus(ACT_TICK, 16'h0000, 8'h00, 9'd5, 1'b0));
    add_row(bus(ACT_TICK, 16'h0000, 8'h00, 9'd239, 1'b1), 1'b1, 9'd0, 1'b1, 1'b1, 1'b0);
    add_row(bus(ACT_WRITE, ADDR_IRQ, 8'h00), 1'b1, 9'd0, 1'b1, 1'b0, 1'b1);
    // header mirroring before and after the lock
    add_cfg(CFG_MIRROR, 10'd0);
    add_row(bus(ACT_TICK, 16'h0000, 8'h00, 9'd10, 1'b1), 1'b1, 9'd0, 1'b0, 1'b0, 1'b0);
    add_row(bus(ACT_WRITE, ADDR_MIRR, 8'h40), 1'b1, 9'd0, 1'b1, 1'b0, 1'b1);
    add_cfg(CFG_MIRROR, 10'd0);
    add_row(bus(ACT_WRITE, ADDR_PRG, 8'h00), 1'b1, 9'd0, 1'b1, 1'b0, 1'b1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        idle_bus();
        cfg_write(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      idle_bus();
      cfg_write(CFG_PRG_COUNT, 10'(phase_prg[p]));
      cfg_write(CFG_CHR_COUNT, 10'(phase_chr[p]));
      cfg_write(CFG_MIRROR, 10'(phase_mirr[p]));
      idle_mode = idle_mode_e'(p % 4);
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
    end

    idle_bus();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (results_due.size() != 0)
      report_mismatch("results never delivered, count", 0, results_due.size());

    $display("covered %0d transfers: directed table plus %0d random phases under all idle patterns",
             items_sent, PHASES);
    $display("%0d results checked, %0d counter wraps, bank counts down to zero and up to 512",
             results_seen, counter_wraps);
    if (errors == 0) begin
      $display("nes_bank_mapper_irq_core_tb: PASS");
    end else begin
      $display("nes_bank_mapper_irq_core_tb: FAIL");
    end
    $finish;
  end

endmodule
